@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file icpm_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ICPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ICPM_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/icpm_pkg.sv @@
// ----------------------------------------------------------------------------
// icpm_pkg
// Types and constants of the input capture period meter.
// ----------------------------------------------------------------------------
package icpm_pkg;

  localparam int unsigned CntBits     = 16;
  localparam int unsigned WrapBits    = 6;
  localparam int unsigned PeriodBits  = CntBits + WrapBits;
  localparam int unsigned FreqBits    = 24;
  localparam int unsigned OffsetBits  = 8;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned DivSteps    = FreqBits;
  localparam int unsigned DivCntBits  = $clog2(DivSteps);

  localparam logic [WrapBits-1:0]    WrapMax       = '1;
  localparam logic [CntBits-1:0]     CntAllOnes    = '1;
  localparam logic [FreqBits-1:0]    TimebaseReset = 24'd1000000;
  localparam logic [OffsetBits-1:0]  OffsetReset   = 8'd10;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgTimebase = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgOffset   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StDivide,
    StDeliver
  } icpm_state_e;

  typedef struct packed {
    logic take_event;
    logic start_calc;
    logic div_step;
    logic load_result;
  } icpm_cmd_t;

  typedef struct packed {
    logic finish;
    logic bad;
    logic div_last;
  } icpm_sts_t;

endpackage

@@ rtl/icpm_if.sv @@
// ----------------------------------------------------------------------------
// icpm_if
// Request channels of the period meter: timer events in, results out.
// ----------------------------------------------------------------------------
interface icpm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        overflow_flag;
  logic        capture_flag;
  logic [15:0] capture_value;

  modport source (output valid, command, overflow_flag, capture_flag, capture_value,
                  input ready);
  modport sink   (input valid, command, overflow_flag, capture_flag, capture_value,
                  output ready);
endinterface

interface icpm_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] period_ticks;
  logic [23:0] frequency;
  logic        too_long;
  logic        bad_period;

  modport source (output valid, period_ticks, frequency, too_long, bad_period,
                  input ready);
  modport sink   (input valid, period_ticks, frequency, too_long, bad_period,
                  output ready);
endinterface

@@ rtl/icpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// icpm_ctrl
// Sequencer: event intake, period calculation, divide, result hand-over.
// ----------------------------------------------------------------------------
module icpm_ctrl import icpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  icpm_sts_t sts_i,
  output icpm_cmd_t cmd_o
);

  icpm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.take_event && sts_i.finish) state_d = StCalc;
      end
      StCalc: begin
        state_d = sts_i.bad ? StDeliver : StDivide;
      end
      StDivide: begin
        if (sts_i.div_last) state_d = StDeliver;
      end
      StDeliver: begin
        if (cmd_o.load_result) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == StIdle);
    cmd_o.take_event  = in_valid_i && (state_q == StIdle);
    cmd_o.start_calc  = (state_q == StCalc);
    cmd_o.div_step    = (state_q == StDivide);
    // result register is free or being emptied this cycle
    cmd_o.load_result = (state_q == StDeliver) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_result) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/icpm_dp.sv @@
// ----------------------------------------------------------------------------
// icpm_dp
// Datapath: settings, measurement state, period subtractor, restoring
// divider and result register.
// ----------------------------------------------------------------------------
module icpm_dp import icpm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   command_i,
  input  logic                   overflow_flag_i,
  input  logic                   capture_flag_i,
  input  logic [CntBits-1:0]     capture_value_i,
  input  icpm_cmd_t              cmd_i,
  output icpm_sts_t              sts_o,
  output logic [PeriodBits-1:0]  period_ticks_o,
  output logic [FreqBits-1:0]    frequency_o,
  output logic                   too_long_o,
  output logic                   bad_period_o
);

  logic [FreqBits-1:0]   timebase_q;
  logic [OffsetBits-1:0] offset_q;

  logic                started_q, started_d;
  logic                finished_q, finished_d;
  logic [WrapBits-1:0] wraps_q, wraps_d;
  logic [CntBits-1:0]  first_q, first_d;
  logic [CntBits-1:0]  second_q, second_d;
  logic                done_now, saturated;

  logic [PeriodBits-1:0] period_q;
  logic                  sat_q;
  logic                  bad_q;
  logic [PeriodBits-1:0] divisor_q;
  logic [PeriodBits-1:0] rem_q, rem_d;
  logic [FreqBits-1:0]   quo_q, quo_d;
  logic [DivCntBits-1:0] cnt_q;
  logic [PeriodBits+1:0] trial;
  logic                  fits;
  logic                  bad_now;

  logic [PeriodBits-1:0] res_period_q;
  logic [FreqBits-1:0]   res_freq_q;
  logic                  res_long_q, res_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timebase_q <= TimebaseReset;
      offset_q   <= OffsetReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimebase: timebase_q <= cfg_data_i;
        CfgOffset:   offset_q   <= cfg_data_i[OffsetBits-1:0];
        default: ;
      endcase
    end
  end

  // event update: overflow first, then capture
  always_comb begin
    started_d  = started_q;
    finished_d = finished_q;
    wraps_d    = wraps_q;
    first_d    = first_q;
    second_d   = second_q;
    done_now   = 1'b0;
    saturated  = 1'b0;
    if (command_i) begin
      started_d  = 1'b0;
      finished_d = 1'b0;
      wraps_d    = '0;
      first_d    = '0;
      second_d   = '0;
    end else if (!finished_q) begin
      if (overflow_flag_i && started_q) begin
        if (wraps_q == WrapMax) begin
          finished_d = 1'b1;
          done_now   = 1'b1;
          saturated  = 1'b1;
          second_d   = CntAllOnes;
        end else begin
          wraps_d = wraps_q + 1'b1;
        end
      end
      if (capture_flag_i) begin
        if (started_q) begin
          started_d  = 1'b0;
          finished_d = 1'b1;
          done_now   = 1'b1;
          second_d   = capture_value_i;
        end else begin
          started_d = 1'b1;
          wraps_d   = '0;
          second_d  = '0;
          first_d   = capture_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      wraps_q    <= '0;
      first_q    <= '0;
      second_q   <= '0;
    end else if (cmd_i.take_event) begin
      started_q  <= started_d;
      finished_q <= finished_d;
      wraps_q    <= wraps_d;
      first_q    <= first_d;
      second_q   <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_event && done_now) begin
      period_q <= {wraps_d, second_d} - {{WrapBits{1'b0}}, first_d};
      sat_q    <= saturated;
    end
  end

  assign bad_now = (period_q <= {{(PeriodBits-OffsetBits){1'b0}}, offset_q});

  // restoring divider, one quotient bit a cycle
  always_comb begin
    trial = {1'b0, rem_q, quo_q[FreqBits-1]} - {2'b00, divisor_q};
    fits  = !trial[PeriodBits+1];
    rem_d = fits ? trial[PeriodBits-1:0] : {rem_q[PeriodBits-2:0], quo_q[FreqBits-1]};
    quo_d = {quo_q[FreqBits-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_calc) begin
      bad_q     <= bad_now;
      divisor_q <= period_q - {{(PeriodBits-OffsetBits){1'b0}}, offset_q};
      rem_q     <= '0;
      quo_q     <= timebase_q;
      cnt_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_period_q <= period_q;
      res_freq_q   <= bad_q ? '0 : quo_q;
      res_long_q   <= sat_q;
      res_bad_q    <= bad_q;
    end
  end

  assign sts_o.finish   = done_now;
  assign sts_o.bad      = bad_now;
  assign sts_o.div_last = (cnt_q == DivCntBits'(DivSteps - 1));

  assign period_ticks_o = res_period_q;
  assign frequency_o    = res_freq_q;
  assign too_long_o     = res_long_q;
  assign bad_period_o   = res_bad_q;

endmodule

@@ rtl/input_capture_period_meter.sv @@
// ----------------------------------------------------------------------------
// input_capture_period_meter
// Period and frequency of an input from two captures of a 16-bit timer.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries requests: a rearm (command 1) or a timer event with its
//   overflow flag, capture flag and capture value. An event that ends a
//   measurement yields one request on out_if; all other requests yield none.
//   cfg_* writes timebase_hz (index 0) and period_offset (index 1); the user
//   must write only while the block is idle, which the block does not enforce.
//   A request that yields nothing leaves the block idle and in_if ready. A
//   finishing event with a valid period passes the offset subtract, the
//   restoring divider, one bit a cycle, and the load of the result
//   register; when the period is not above the offset, the divider is
//   skipped.
//   A finishing event keeps in_if not ready until its result is loaded,
//   so the divider limits how often measurements can end.
//   A stalled receiver does not stop intake at first: requests are accepted
//   while a result waits; the next finished result is held back, with in_if
//   not ready, until the waiting one is taken.
//   Reset clears the measurement, drops any pending result and restores the
//   timebase to 1000000 and the offset to 10.
// ----------------------------------------------------------------------------
module input_capture_period_meter import icpm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  icpm_in_if.sink                in_if,
  icpm_out_if.source             out_if
);

  icpm_cmd_t cmd;
  icpm_sts_t sts;

  icpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  icpm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (in_if.command),
    .overflow_flag_i (in_if.overflow_flag),
    .capture_flag_i  (in_if.capture_flag),
    .capture_value_i (in_if.capture_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .period_ticks_o  (out_if.period_ticks),
    .frequency_o     (out_if.frequency),
    .too_long_o      (out_if.too_long),
    .bad_period_o    (out_if.bad_period)
  );

endmodule

@@ rtl/icpm_checker.sv @@
// ----------------------------------------------------------------------------
// icpm_checker
// Port-level checks of the period meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [21:0] period_ticks_i,
  input logic [23:0] frequency_i,
  input logic        too_long_i,
  input logic        bad_period_i
);

  // a result is only loaded from the hand-over state, never right after intake
  `ICPM_ASSERT(a_no_result_after_intake, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !$rose(out_valid_i), "result appeared right after an intake")

  `ICPM_NEVER(a_bad_has_zero_freq, clk_i, rst_ni, out_valid_i && bad_period_i && (frequency_i != 24'd0), "bad period with nonzero frequency")

  // saturated count leaves at least 62 whole wraps in the period
  `ICPM_ASSERT(a_too_long_period, clk_i, rst_ni, (out_valid_i && too_long_i) |-> ((period_ticks_i[21:16] == 6'h3F) || (period_ticks_i[21:16] == 6'h3E)), "too_long with short period")

  `ICPM_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(period_ticks_i) && $stable(frequency_i)), "stalled result changed")

endmodule

bind input_capture_period_meter icpm_checker u_icpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .period_ticks_i (out_if.period_ticks),
  .frequency_i    (out_if.frequency),
  .too_long_i     (out_if.too_long),
  .bad_period_i   (out_if.bad_period)
);

@@ dv/tb_input_capture_period_meter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_input_capture_period_meter
// Self-checking bench for the capture period meter. A short table of
// requests covers rearm, bad periods, wrap-around and ignored events. Random
// capture sequences follow, with short, long and saturating wrap counts,
// under several timebase and offset settings. Every result is compared
// field by field with its table entry or a bench-side model of the measurement.
// ----------------------------------------------------------------------------
module tb_input_capture_period_meter;
  import icpm_pkg::*;

  localparam logic        CmdEvent    = 1'b0;
  localparam logic        CmdRearm    = 1'b1;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned PhaseItems   = 220;
  localparam int unsigned MaxPrinted   = 100;
  localparam int unsigned NumDirected  = 23;

  typedef struct packed {
    logic               command;
    logic               overflow_flag;
    logic               capture_flag;
    logic [CntBits-1:0] capture_value;
  } meter_req_t;

  typedef struct packed {
    logic [PeriodBits-1:0] period_ticks;
    logic [FreqBits-1:0]   frequency;
    logic                  too_long;
    logic                  bad_period;
  } meter_res_t;

  typedef struct packed {
    meter_req_t req;
    logic       fixed_result;
    meter_res_t res;
  } stim_row_t;

  typedef enum logic [1:0] {
    SeqShort,
    SeqLong,
    SeqOverride,
    SeqSaturate
  } seq_kind_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  icpm_in_if  event_if ();
  icpm_out_if result_if ();

  input_capture_period_meter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (event_if),
    .out_if     (result_if)
  );

  always #5 clk_i = ~clk_i;

  // measurement model state
  logic                  meter_started;
  logic                  meter_finished;
  logic [WrapBits-1:0]   meter_wraps;
  logic [CntBits-1:0]    meter_first_edge;
  logic [CntBits-1:0]    meter_second_edge;
  logic [FreqBits-1:0]   timebase_hz_q;
  logic [OffsetBits-1:0] period_offset_q;

  meter_res_t  expected_results[$];
  int unsigned error_count     = 0;
  int unsigned effective_items = 0;
  int unsigned cycle_count     = 0;
  bit          no_idle         = 1'b0;

  function automatic void clear_measurement();
    meter_started     = 1'b0;
    meter_finished    = 1'b0;
    meter_wraps       = '0;
    meter_first_edge  = '0;
    meter_second_edge = '0;
  endfunction

  // Returns 1 when the request ends a measurement, with the result in res.
  function automatic logic predict_measurement(input meter_req_t req, output meter_res_t res);
    logic                  done;
    logic                  saturated;
    logic [PeriodBits-1:0] period;
    done      = 1'b0;
    saturated = 1'b0;
    res       = '0;
    if (req.command == CmdRearm) begin
      clear_measurement();
      return 1'b0;
    end
    if (meter_finished) return 1'b0;
    // overflow is handled before the capture of the same event
    if (req.overflow_flag && meter_started) begin
      if (meter_wraps == WrapMax) begin
        meter_finished    = 1'b1;
        done              = 1'b1;
        saturated         = 1'b1;
        meter_second_edge = CntAllOnes;
      end else begin
        meter_wraps = meter_wraps + 1'b1;
      end
    end
    if (req.capture_flag) begin
      if (meter_started) begin
        meter_started     = 1'b0;
        meter_finished    = 1'b1;
        done              = 1'b1;
        meter_second_edge = req.capture_value;
      end else begin
        meter_wraps       = '0;
        meter_second_edge = '0;
        meter_started     = 1'b1;
        meter_first_edge  = req.capture_value;
      end
    end
    if (!done) return 1'b0;
    period = {meter_wraps, {CntBits{1'b0}}} + PeriodBits'(meter_second_edge)
             - PeriodBits'(meter_first_edge);
    res.period_ticks = period;
    res.too_long     = saturated;
    res.bad_period   = (period <= PeriodBits'(period_offset_q));
    if (!res.bad_period)
      res.frequency = FreqBits'(32'(timebase_hz_q) / 32'(period - PeriodBits'(period_offset_q)));
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MaxPrinted)
      $display("[%0d] %s: got %0h, want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic meter_req_t make_request(input logic cmd, input logic ovf, input logic cap,
                                              input logic [CntBits-1:0] val);
    meter_req_t req;
    req.command       = cmd;
    req.overflow_flag = ovf;
    req.capture_flag  = cap;
    req.capture_value = val;
    return req;
  endfunction

  function automatic meter_req_t random_request();
    return make_request(($urandom_range(0, 7) == 0) ? CmdRearm : CmdEvent, 1'($urandom),
                        1'($urandom), CntBits'($urandom));
  endfunction

  function automatic logic [CntBits-1:0] pick_edge();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CntAllOnes;
      default: return CntBits'($urandom);
    endcase
  endfunction

  // Drives one request and updates the model when it is taken.
  task automatic send_request(input meter_req_t req, input logic use_fixed = 1'b0,
                              input meter_res_t fixed = '0);
    int unsigned gap;
    meter_res_t  res;
    logic        produced;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      event_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    event_if.valid         <= 1'b1;
    event_if.command       <= req.command;
    event_if.overflow_flag <= req.overflow_flag;
    event_if.capture_flag  <= req.capture_flag;
    event_if.capture_value <= req.capture_value;
    do @(posedge clk_i); while (event_if.ready !== 1'b1);
    if (!(req.command == CmdEvent &&
          (meter_finished || (!meter_started && !req.capture_flag))))
      effective_items++;
    produced = predict_measurement(req, res);
    if (use_fixed) expected_results.push_back(fixed);
    else if (produced) expected_results.push_back(res);
  endtask

  // Stops requests, waits for every pending result and lets the divider settle.
  task automatic quiesce_block();
    @(negedge clk_i);
    event_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [FreqBits-1:0] timebase,
                                input logic [OffsetBits-1:0] offset);
    quiesce_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgTimebase;
    cfg_data_i <= CfgDataBits'(timebase);
    @(negedge clk_i);
    cfg_idx_i  <= CfgOffset;
    cfg_data_i <= CfgDataBits'(offset);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    timebase_hz_q   = timebase;
    period_offset_q = offset;
  endtask

  task automatic run_measurement(input seq_kind_e kind);
    logic [CntBits-1:0] first;
    logic [CntBits-1:0] last;
    int unsigned        wraps;
    if ($urandom_range(0, 7) != 0)
      send_request(make_request(CmdRearm, 1'($urandom), 1'($urandom), CntBits'($urandom)));
    first = pick_edge();
    send_request(make_request(CmdEvent, 1'($urandom), 1'b1, first));
    case (kind)
      SeqSaturate: wraps = int'(WrapMax) + 1;
      SeqOverride: wraps = int'(WrapMax);
      SeqLong:     wraps = $urandom_range(int'(WrapMax) - 3, int'(WrapMax) - 1);
      default:     wraps = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
    endcase
    for (int unsigned i = 0; i < wraps; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_request(make_request(CmdEvent, 1'b0, 1'b0, CntBits'($urandom)));
      // the saturating overflow may carry a capture that overrides the end value
      send_request(make_request(CmdEvent, 1'b1,
                                (kind == SeqSaturate && i == wraps - 1) ? 1'($urandom) : 1'b0,
                                CntBits'($urandom)));
    end
    if (kind != SeqSaturate) begin
      last = $urandom_range(0, 1) ? first + CntBits'($urandom_range(0, 300)) : pick_edge();
      send_request(make_request(CmdEvent,
                                (kind == SeqOverride) ? 1'b1 : ($urandom_range(0, 3) == 0),
                                1'b1, last));
    end
    if ($urandom_range(0, 3) == 0) send_request(random_request());
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned first_count;
    int unsigned pick;
    first_count = effective_items;
    while (effective_items - first_count < n_items) begin
      no_idle = ($urandom_range(0, 5) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 8)       send_request(random_request());
      else if (pick == 8) run_measurement(SeqSaturate);
      else if (pick == 9) run_measurement(SeqOverride);
      else if (pick < 12) run_measurement(SeqLong);
      else                run_measurement(SeqShort);
      if ($urandom_range(0, 29) == 0) quiesce_block();
    end
    no_idle = 1'b0;
  endtask

  stim_row_t directed_rows [NumDirected] = '{
    '{'{CmdRearm, 1'b1, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'h0000}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'h0000}, 1'b1, '{22'd0, 24'd0, 1'b0, 1'b1}},
    '{'{CmdEvent, 1'b1, 1'b1, 16'h1234}, 1'b0, '0},
    '{'{CmdRearm, 1'b0, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'd100},  1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'd110},  1'b1, '{22'd10, 24'd0, 1'b0, 1'b1}},
    '{'{CmdRearm, 1'b0, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'h0000}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'd11},   1'b1, '{22'd11, 24'd1000000, 1'b0, 1'b0}},
    '{'{CmdRearm, 1'b0, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{CmdEvent, 1'b1, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{CmdEvent, 1'b1, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'h0000}, 1'b0, '0},
    '{'{CmdRearm, 1'b0, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'd50},   1'b0, '0},
    '{'{CmdEvent, 1'b1, 1'b0, 16'hABCD}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b0, 16'h5555}, 1'b0, '0},
    '{'{CmdEvent, 1'b1, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{CmdRearm, 1'b1, 1'b0, 16'hAAAA}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'h5555}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'hAAAA}, 1'b0, '0},
    '{'{CmdEvent, 1'b0, 1'b1, 16'h0000}, 1'b0, '0}
  };

  initial begin : stimulus
    event_if.valid         = 1'b0;
    event_if.command       = CmdEvent;
    event_if.overflow_flag = 1'b0;
    event_if.capture_flag  = 1'b0;
    event_if.capture_value = '0;
    result_if.ready        = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CfgTimebase;
    cfg_data_i             = '0;
    rst_ni                 = 1'b0;
    clear_measurement();
    timebase_hz_q   = TimebaseReset;
    period_offset_q = OffsetReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_request(directed_rows[k].req, directed_rows[k].fixed_result, directed_rows[k].res);
    run_measurement(SeqSaturate);
    run_measurement(SeqOverride);
    random_phase(PhaseItems);

    apply_settings(24'hFFFFFF, 8'd0);
    random_phase(PhaseItems);
    apply_settings(24'd1, 8'd255);
    random_phase(PhaseItems);
    apply_settings(24'd0, 8'd128);
    random_phase(PhaseItems);
    apply_settings(FreqBits'($urandom_range(1, 24'hFFFFFF)), OffsetBits'($urandom));
    random_phase(PhaseItems);
    apply_settings(FreqBits'($urandom_range(1, 1000)), OffsetBits'($urandom_range(0, 15)));
    random_phase(PhaseItems);
    apply_settings(FreqBits'($urandom_range(1, 24'hFFFFFF)), OffsetBits'($urandom));
    random_phase(PhaseItems);

    quiesce_block();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      @(negedge clk_i);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (result_if.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    meter_res_t want;
    if (rst_ni && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(result_if.period_ticks), '0);
      end else begin
        want = expected_results.pop_front();
        if (result_if.period_ticks !== want.period_ticks)
          report_mismatch("period_ticks", 32'(result_if.period_ticks), 32'(want.period_ticks));
        if (result_if.frequency !== want.frequency)
          report_mismatch("frequency", 32'(result_if.frequency), 32'(want.frequency));
        if (result_if.too_long !== want.too_long)
          report_mismatch("too_long", 32'(result_if.too_long), 32'(want.too_long));
        if (result_if.bad_period !== want.bad_period)
          report_mismatch("bad_period", 32'(result_if.bad_period), 32'(want.bad_period));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
